// ===== hdl/dac_persist_save_scheduler_defines.svh =====
// Assertion macros shared by the save scheduler's checker.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef DAC_PERSIST_SAVE_SCHEDULER_DEFINES_SVH
`define DAC_PERSIST_SAVE_SCHEDULER_DEFINES_SVH

// Clocked check, held off while reset is asserted
`define DPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define DPS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/dps_pkg.sv =====
// Shared types and constants of the DAC persist save scheduler.
// No dependencies; imported by every module of the block.
package dps_pkg;

	// Default DAC resolution
	localparam int DAC_BITS_DEF = 12;

	// Fixed field widths
	localparam int LEVEL_W  = 12;
	localparam int CMD_W    = 7;
	localparam int WORD_W   = 16;
	localparam int TIME_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;

	// Bus commands
	localparam logic [CMD_W-1:0] CMD_VOLATILE    = 7'h40;
	localparam logic [CMD_W-1:0] CMD_NONVOLATILE = 7'h60;

	// Request kinds
	typedef enum logic [1:0] {
		KIND_SET     = 2'd0,
		KIND_TICK    = 2'd1,
		KIND_RESTORE = 2'd2
	} kind_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAVE_ENABLE      = 2'd0,
		REG_CHANGE_THRESHOLD = 2'd1,
		REG_MIN_INTERVAL     = 2'd2,
		REG_DEBOUNCE         = 2'd3
	} cfg_reg_t;

	// One input request
	typedef struct packed {
		kind_t              kind;
		logic [LEVEL_W-1:0] level_code;
		logic               bus_ok;
	} item_t;

	// One result
	typedef struct packed {
		logic [CMD_W-1:0]  bus_command;
		logic [WORD_W-1:0] data_word;
		logic              save_scheduled;
	} result_t;

	// Configuration write
	typedef struct packed {
		logic                  valid;
		cfg_reg_t              index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

// ===== hdl/dps_in_reg.sv =====
// Input register stage of the save scheduler.
// Depends on dps_pkg for the request type.
module dps_in_reg
	import dps_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  item_fire,
	output item_t item_s1
);

	logic valid_s1;

	assign in_ready  = !valid_s1 || advance;
	assign item_fire = valid_s1 && advance;

	// Hold one request until the core can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== hdl/dps_core.sv =====
// Scheduler core: configuration, time and save state, and the per-request decision.
// Depends on dps_pkg for types, commands and register indexes.
module dps_core
	import dps_pkg::*;
#(
	parameter int DAC_BITS = DAC_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg_wr,
	input  logic    item_fire,
	input  item_t   item,
	output logic    res_valid,
	output result_t res
);

	localparam int CW    = (DAC_BITS < LEVEL_W) ? DAC_BITS : LEVEL_W;
	localparam int SHIFT = WORD_W - DAC_BITS;

	// Configuration
	logic              save_enable_q;
	logic [LEVEL_W-1:0] change_threshold_q;
	logic [TIME_W-1:0] min_interval_q;
	logic [TIME_W-1:0] debounce_q;

	// State
	logic [TIME_W-1:0] time_q;
	logic [CW-1:0]     persisted_code_q;
	logic              persisted_valid_q;
	logic [TIME_W-1:0] last_save_time_q;
	logic              save_pending_q;
	logic [TIME_W-1:0] save_due_time_q;
	logic [CW-1:0]     pending_code_q;

	// Decision terms
	logic [CW-1:0]     code;
	logic [CW-1:0]     diff;
	logic              differs;
	logic [TIME_W-1:0] interval_end;
	logic              interval_ok;
	logic [TIME_W-1:0] time_inc;
	logic              save_due;
	logic              sched;

	function automatic logic [WORD_W-1:0] to_word(input logic [CW-1:0] c);
		logic [WORD_W-1:0] w;
		w = WORD_W'(c);
		return w << SHIFT;
	endfunction

	// Set and tick conditions
	always_comb begin
		code         = item.level_code[CW-1:0];
		diff         = (code >= persisted_code_q) ? (code - persisted_code_q)
		                                          : (persisted_code_q - code);
		differs      = !persisted_valid_q || (LEVEL_W'(diff) >= change_threshold_q);
		interval_end = last_save_time_q + min_interval_q;
		interval_ok  = !(time_q < interval_end);
		sched        = save_enable_q && differs && interval_ok;
		time_inc     = time_q + TIME_W'(1);
		save_due     = save_pending_q && !(time_inc < save_due_time_q);
	end

	// Result of the request in the input stage
	always_comb begin
		res_valid          = 1'b0;
		res.bus_command    = CMD_VOLATILE;
		res.data_word      = to_word(code);
		res.save_scheduled = 1'b0;
		case (item.kind)
			KIND_SET: begin
				res_valid          = item_fire;
				res.save_scheduled = sched;
			end
			KIND_TICK: begin
				res_valid       = item_fire && save_due;
				res.bus_command = CMD_NONVOLATILE;
				res.data_word   = to_word(pending_code_q);
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			save_enable_q      <= 1'b0;
			change_threshold_q <= '0;
			min_interval_q     <= '0;
			debounce_q         <= '0;
		end else if (cfg_wr.valid) begin
			case (cfg_wr.index)
				REG_SAVE_ENABLE:      save_enable_q      <= cfg_wr.data[0];
				REG_CHANGE_THRESHOLD: change_threshold_q <= cfg_wr.data[LEVEL_W-1:0];
				REG_MIN_INTERVAL:     min_interval_q     <= cfg_wr.data[TIME_W-1:0];
				REG_DEBOUNCE:         debounce_q         <= cfg_wr.data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Time and save state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q            <= '0;
			persisted_code_q  <= '0;
			persisted_valid_q <= 1'b0;
			last_save_time_q  <= '0;
			save_pending_q    <= 1'b0;
			save_due_time_q   <= '0;
			pending_code_q    <= '0;
		end else if (item_fire) begin
			case (item.kind)
				KIND_SET: begin
					if (sched) begin
						save_due_time_q <= time_q + debounce_q;
						pending_code_q  <= code;
						save_pending_q  <= 1'b1;
					end
				end
				KIND_TICK: begin
					time_q <= time_inc;
					if (save_due) begin
						save_pending_q <= 1'b0;
						if (item.bus_ok) begin
							last_save_time_q  <= time_inc;
							persisted_code_q  <= pending_code_q;
							persisted_valid_q <= 1'b1;
						end
					end
				end
				KIND_RESTORE: begin
					persisted_code_q  <= code;
					persisted_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/dps_out_reg.sv =====
// Output register of the save scheduler.
// Depends on dps_pkg for the result type.
module dps_out_reg
	import dps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	output logic    advance,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    valid_q;
	result_t res_q;

	assign advance   = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

endmodule

// ===== hdl/dac_persist_save_scheduler.sv =====
// Top level of the DAC persist save scheduler: input register, core, output register.
// Depends on dps_pkg, dps_in_reg, dps_core and dps_out_reg.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: level_code, bus_ok; tuser: kind
//  m_axis    out  m_axis_tvalid/tready       tdata: bus_command, data_word, save_scheduled
//  cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One request per cycle unless the input stalls; each result is registered.
// The input register and the output register each hold one request, so the
// input stalls only while the output register is full and not taken.
// Configuration writes are always ready and take effect on the next cycle.
// Reset (arst_n low) clears settings, time, persisted and pending state, valid flags.
module dac_persist_save_scheduler
	import dps_pkg::*;
#(
	parameter int DAC_BITS = DAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [11:0] level_code, [12] bus_ok
	input  logic [1:0]            s_axis_tuser,  // [1:0] kind
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_TDATA_W-1:0]  m_axis_tdata,  // [6:0] bus_command, [22:7] data_word,
	                                             // [23] save_scheduled
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	item_t   in_item;
	item_t   item_s1;
	logic    item_fire;
	logic    advance;
	logic    res_valid;
	result_t res;
	result_t out_res;
	cfg_wr_t cfg_wr;

	// Unpack request
	assign in_item.kind       = kind_t'(s_axis_tuser);
	assign in_item.level_code = s_axis_tdata[LEVEL_W-1:0];
	assign in_item.bus_ok     = s_axis_tdata[LEVEL_W];

	// Configuration write
	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_reg_t'(cfg_index);
	assign cfg_wr.data  = cfg_data;

	dps_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.advance   (advance),
		.item_fire (item_fire),
		.item_s1   (item_s1)
	);

	dps_core #(
		.DAC_BITS (DAC_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.item_fire (item_fire),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	dps_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// Pack result
	assign m_axis_tdata = {out_res.save_scheduled, out_res.data_word, out_res.bus_command};

endmodule

// ===== hdl/dps_checker.sv =====
// Port-level checks of the DAC persist save scheduler, bound to the top level.
// Depends on dac_persist_save_scheduler_defines.svh and dps_pkg.
`include "dac_persist_save_scheduler_defines.svh"

module dps_checker
	import dps_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);

	logic [CMD_W-1:0] cmd;

	assign cmd = m_axis_tdata[CMD_W-1:0];

	// A stalled result holds
	`DPS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// Only the two bus commands are produced
	`DPS_ASSERT(a_cmd_legal, m_axis_tvalid |-> (cmd == CMD_VOLATILE) || (cmd == CMD_NONVOLATILE), "illegal bus command")

	// A scheduled save is reported only on a volatile write
	`DPS_ASSERT(a_sched_on_set, m_axis_tvalid && m_axis_tdata[M_TDATA_W-1] |-> cmd == CMD_VOLATILE, "save flag on non-volatile write")

	// Input stalls only behind a full, untaken output register
	`DPS_ASSERT(a_in_stall, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

endmodule

bind dac_persist_save_scheduler dps_checker u_dps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb_dac_persist_save_scheduler.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dac_persist_save_scheduler: random and directed level, tick and
// restore requests checked against an in-bench scheduler model. Depends on dps_pkg and the RTL.
module tb_dac_persist_save_scheduler;
	import dps_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT = 5000;
	localparam logic [LEVEL_W-1:0] CODE_MAX = {LEVEL_W{1'b1}};

	typedef struct packed {
		logic [1:0]         kind;
		logic [LEVEL_W-1:0] code;
		logic               ok;
	} req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata = '0;  // [11:0] level_code, [12] bus_ok
	logic [1:0]            s_axis_tuser = '0;  // [1:0] kind
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;  // [6:0] bus_command, [22:7] data_word,
	                                      // [23] save_scheduled
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	dac_persist_save_scheduler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// Scheduler model: settings and state
	logic               cfg_enable = 1'b0;
	logic [LEVEL_W-1:0] cfg_thresh = '0;
	logic [TIME_W-1:0]  cfg_min_gap = '0;
	logic [TIME_W-1:0]  cfg_debounce = '0;
	logic [TIME_W-1:0]  ms_now = '0;
	logic [LEVEL_W-1:0] saved_code = '0;
	logic               saved_valid = 1'b0;
	logic [TIME_W-1:0]  last_write_ms = '0;
	logic               save_armed = 1'b0;
	logic [TIME_W-1:0]  due_ms = '0;
	logic [LEVEL_W-1:0] armed_code = '0;

	req_t    request_q[$];
	result_t bus_write_q[$];
	req_t    req_on_bus;
	int      idle_pct = 0;
	int      stall_pct = 0;
	int      errors = 0;
	int      n_req = 0, n_set = 0, n_tick = 0, n_nv = 0, n_sched = 0;
	int      quiet_cycles = 0;
	logic [LEVEL_W-1:0] gen_code = '0;

	// Next bus write caused by one request; updates the model state
	function automatic bit predict_bus_write(input req_t r, output result_t res);
		logic [LEVEL_W-1:0] diff;
		logic [TIME_W-1:0]  gap_end;
		res = '0;
		case (r.kind)
			KIND_SET: begin
				res.bus_command = CMD_VOLATILE;
				res.data_word = {r.code, 4'b0000};
				diff = (r.code >= saved_code) ? r.code - saved_code : saved_code - r.code;
				gap_end = last_write_ms + cfg_min_gap;
				if (cfg_enable && (!saved_valid || diff >= cfg_thresh) && !(ms_now < gap_end)) begin
					due_ms = ms_now + cfg_debounce;
					armed_code = r.code;
					save_armed = 1'b1;
					res.save_scheduled = 1'b1;
				end
				return 1'b1;
			end
			KIND_TICK: begin
				ms_now = ms_now + 1;
				if (!save_armed || ms_now < due_ms)
					return 1'b0;
				res.bus_command = CMD_NONVOLATILE;
				res.data_word = {armed_code, 4'b0000};
				// failed write drops the save, no retry
				if (r.ok) begin
					last_write_ms = ms_now;
					saved_code = armed_code;
					saved_valid = 1'b1;
				end
				save_armed = 1'b0;
				return 1'b1;
			end
			KIND_RESTORE: begin
				saved_code = r.code;
				saved_valid = 1'b1;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Request driver
	always @(posedge clk) begin
		result_t res;
		if (s_axis_tvalid && s_axis_tready) begin
			n_req++;
			if (predict_bus_write(req_on_bus, res))
				bus_write_q.push_back(res);
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (request_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
				req_on_bus = request_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {3'b000, req_on_bus.ok, req_on_bus.code};
				s_axis_tuser <= req_on_bus.kind;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result side back-pressure
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

	// Result monitor
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.bus_command = m_axis_tdata[6:0];
			got.data_word = m_axis_tdata[22:7];
			got.save_scheduled = m_axis_tdata[23];
			if (got.bus_command == CMD_NONVOLATILE)
				n_nv++;
			if (got.save_scheduled)
				n_sched++;
			if (bus_write_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected bus write cmd=%h word=%h sched=%b",
						got.bus_command, got.data_word, got.save_scheduled);
			end else begin
				want = bus_write_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: bus write exp cmd=%h word=%h sched=%b, got cmd=%h word=%h sched=%b",
							want.bus_command, want.data_word, want.save_scheduled,
							got.bus_command, got.data_word, got.save_scheduled);
				end
			end
		end
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("ERROR: no progress for %0d cycles", STALL_LIMIT);
			$display("tb_dac_persist_save_scheduler: done, errors");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	function automatic void push_req(input logic [1:0] kind, input logic [LEVEL_W-1:0] code,
			input logic ok);
		req_t r;
		r.kind = kind;
		r.code = code;
		r.ok = ok;
		if (kind == KIND_SET)
			n_set++;
		if (kind == KIND_TICK)
			n_tick++;
		request_q.push_back(r);
	endfunction

	// Random requests: mostly sets near the last level and ticks
	task automatic queue_requests(input int n);
		int pick;
		logic [LEVEL_W-1:0] code;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 3))
				0: code = LEVEL_W'($urandom_range(0, CODE_MAX));
				1: code = $urandom_range(0, 1) ? CODE_MAX : '0;
				default: code = gen_code + LEVEL_W'($urandom_range(0, 12)) - LEVEL_W'(6);
			endcase
			if (pick < 38) begin
				gen_code = code;
				push_req(KIND_SET, code, 1'($urandom_range(0, 1)));
			end else if (pick < 45)
				push_req(KIND_RESTORE, code, 1'($urandom_range(0, 1)));
			else if (pick < 48)
				push_req(KIND_UNUSED, code, 1'($urandom_range(0, 1)));
			else
				push_req(KIND_TICK, code, $urandom_range(0, 7) != 0);
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SAVE_ENABLE:      cfg_enable = val[0];
			REG_CHANGE_THRESHOLD: cfg_thresh = val[LEVEL_W-1:0];
			REG_MIN_INTERVAL:     cfg_min_gap = val;
			REG_DEBOUNCE:         cfg_debounce = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic en, input logic [LEVEL_W-1:0] thr,
			input logic [TIME_W-1:0] gap, input logic [TIME_W-1:0] deb);
		write_reg(REG_SAVE_ENABLE, {31'b0, en});
		write_reg(REG_CHANGE_THRESHOLD, {20'b0, thr});
		write_reg(REG_MIN_INTERVAL, gap);
		write_reg(REG_DEBOUNCE, deb);
	endtask

	// Wait until every request is in and every bus write is out, then let the pipe empty
	task automatic drain();
		do @(posedge clk);
		while (request_q.size() > 0 || s_axis_tvalid || bus_write_q.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: saving off, unused kind ignored
		push_req(KIND_SET, CODE_MAX, 1'b1);
		push_req(KIND_TICK, 12'h000, 1'b1);
		push_req(KIND_UNUSED, 12'hAAA, 1'b1);
		drain();

		// Directed: interval gate, replace, threshold edge, failed write, restore
		apply_settings(1'b1, 12'd4, 32'd3, 32'd2);
		push_req(KIND_SET, 12'h000, 1'b0);
		push_req(KIND_TICK, 12'h000, 1'b1);
		push_req(KIND_TICK, 12'h000, 1'b1);
		push_req(KIND_SET, CODE_MAX, 1'b1);
		push_req(KIND_SET, 12'h800, 1'b0);
		push_req(KIND_TICK, 12'h000, 1'b1);
		push_req(KIND_TICK, 12'h000, 1'b1);
		push_req(KIND_SET, 12'h900, 1'b1);
		push_req(KIND_TICK, 12'h000, 1'b1);
		push_req(KIND_TICK, 12'h000, 1'b1);
		push_req(KIND_TICK, 12'h000, 1'b1);
		push_req(KIND_SET, 12'h803, 1'b1);
		push_req(KIND_SET, 12'h7FC, 1'b1);
		push_req(KIND_TICK, 12'h000, 1'b1);
		push_req(KIND_TICK, 12'h000, 1'b0);
		push_req(KIND_RESTORE, 12'h555, 1'b0);
		push_req(KIND_SET, 12'h556, 1'b1);
		push_req(KIND_SET, 12'h000, 1'b1);
		push_req(KIND_TICK, 12'h000, 1'b1);
		push_req(KIND_TICK, 12'h000, 1'b1);
		push_req(KIND_UNUSED, 12'h5A5, 1'b0);
		drain();

		// Random phases over several settings and idle patterns
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 56; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 56; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase
			case (p)
				0: apply_settings(1'b1, '0, '0, '0);
				1: apply_settings(1'b1, CODE_MAX, '0, 32'd1);
				3: apply_settings(1'b0, 12'd3, '0, '0);
				4: apply_settings(1'b1, LEVEL_W'($urandom_range(0, 8)), '1, '1);
				5: apply_settings(1'b1, LEVEL_W'($urandom_range(0, 8)), '0, '1);
				7: apply_settings(1'b1, 12'd1, 32'd2, 32'd3);
				default: apply_settings(1'b1, LEVEL_W'($urandom_range(0, 8)),
					$urandom_range(0, 10), $urandom_range(0, 6));
			endcase
			queue_requests(50);
			// hold off until every bus write of the first half is out
			do @(posedge clk);
			while (request_q.size() > 0 || s_axis_tvalid || bus_write_q.size() > 0);
			queue_requests(50);
			drain();
		end

		$display("Covered %0d requests (%0d sets, %0d ticks) over 10 settings and 4 idle patterns;",
			n_req, n_set, n_tick);
		$display("saw %0d saves scheduled and %0d non-volatile writes, %0d mismatches.",
			n_sched, n_nv, errors);
		if (errors == 0)
			$display("tb_dac_persist_save_scheduler: done, clean");
		else
			$display("tb_dac_persist_save_scheduler: done, errors");
		$finish;
	end

endmodule
